// ===== hw/rtl/gvc_pkg.sv =====
// ----------------------------------------------------------------------------
// gvc_pkg
// Shared types and constants of the grid visibility checker: the input and
// result words, cell type codes, and the command and status bundles that
// join the controller and the datapath.
// ----------------------------------------------------------------------------
package gvc_pkg;

    localparam int COORD_W      = 6;
    localparam int CELL_W       = 2;
    localparam int STEP_W       = 7;
    localparam int GRID_SIDE_DEF = 64;

    localparam logic [STEP_W-1:0] STEP_RESET = 7'd8;

    localparam logic [CELL_W-1:0] CELL_EMPTY    = 2'd0;
    localparam logic [CELL_W-1:0] CELL_OBSTACLE = 2'd3;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic               op;
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic [COORD_W-1:0] end_x;
        logic [COORD_W-1:0] end_y;
        logic [CELL_W-1:0]  cell_type;
    } t_in_word;

    typedef struct packed {
        logic visible;
        logic same_point_error;
        logic write_ignored;
    } t_out_word;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic clear_step;
        logic setup;
        logic scan_step;
        logic cell_write;
    } t_ctrl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
        logic too_far;
        logic same_point;
        logic scan_last;
        logic hit;
        logic cell_empty;
        logic pos_in_grid;
    } t_dp_status;

endpackage

// ===== hw/rtl/grid_visibility_checker.sv =====
// ----------------------------------------------------------------------------
// grid_visibility_checker
// Square grid of 2-bit cell types with guarded cell writes and line of sight
// queries between two grid points.
// ----------------------------------------------------------------------------
// Usage. The input channel carries one word per item: op selects a cell write
// or a visibility query. A write stores cell_type at (pos_x, pos_y) only when
// that cell is still empty and reports write_ignored otherwise. A query from
// (pos_x, pos_y) to (end_x, end_y) first checks the squared distance against
// the squared step limit, then walks the diagonal and, from every
// diagonal point, scans the leftover axis toward the end; any obstacle clears
// visible. Every item yields exactly one result word.
// Sequencing. The controller handles one item at a time. A write passes
// through a read state, a check state that writes an empty cell and the done
// state that loads the result register. A query passes setup, range check,
// the scan of C cells, (min(|dx|,|dy|) + 1) * (||dx| - |dy|| + 1), at most
// 1056, a drain state and done; the single read port scans one cell per cycle.
// An obstacle ends the scan early; an out of range or same point query skips
// it. The result word sits in an output register, so a stalled receiver only
// delays the block once the next result is ready.
// Reset. After reset the block sweeps the cell memory to empty, one cell per
// cycle (GRID_SIDE * GRID_SIDE cells, 4096 at the default size), with the
// input stalled. The configuration register may be written at any time the
// block is idle; it always accepts a write.
// ----------------------------------------------------------------------------
module grid_visibility_checker #(
    parameter int GRID_SIDE = gvc_pkg::GRID_SIDE_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Input item channel.
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  gvc_pkg::t_in_word           i_in_word,
    // Result channel.
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output gvc_pkg::t_out_word          o_out_word,
    // Configuration channel for the step limit.
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [gvc_pkg::STEP_W-1:0]  i_cfg_data
);
    import gvc_pkg::*;

    t_ctrl_cmd  cmd;
    t_dp_status status;

    // The register is a plain flop, so a configuration word is always taken.
    assign o_cfg_ready = 1'b1;

    // The controller owns the input and result handshakes and the result register.
    gvc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_op     (i_in_word.op),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // The datapath holds the cell memory, the range check and the scan walker.
    gvc_dp #(
        .GRID_SIDE (GRID_SIDE)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_word   (i_in_word),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_status    (status)
    );

endmodule

// ===== hw/rtl/gvc_ram.sv =====
// ----------------------------------------------------------------------------
// gvc_ram
// Generic single write port, single read port memory with registered read.
// ----------------------------------------------------------------------------
module gvc_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 4096,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/gvc_dp.sv =====
// ----------------------------------------------------------------------------
// gvc_dp
// Datapath: cell memory, clearing counter, range check, and the scan walker
// that steps over the diagonal points and the leftover span.
// ----------------------------------------------------------------------------
module gvc_dp #(
    parameter int GRID_SIDE = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  gvc_pkg::t_in_word                    i_in_word,
    input  logic                                 i_cfg_valid,
    input  logic [gvc_pkg::STEP_W-1:0]           i_cfg_data,
    input  gvc_pkg::t_ctrl_cmd                   i_cmd,
    output gvc_pkg::t_dp_status                  o_status
);
    import gvc_pkg::*;

    localparam int DEPTH  = GRID_SIDE * GRID_SIDE;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int SQ_W   = 2 * COORD_W;
    localparam int SUM_W  = SQ_W + 1;
    localparam int LIM_W  = 2 * STEP_W;

    logic [STEP_W-1:0]  r_max_step;
    logic [ADDR_W-1:0]  r_clr_addr;
    logic               r_chk_vld;

    logic [COORD_W-1:0] r_pos_x, r_pos_y, r_end_x, r_end_y;
    logic [CELL_W-1:0]  r_cell_type;
    logic [COORD_W-1:0] r_cur_x, r_cur_y, r_base_x, r_base_y;
    logic [COORD_W-1:0] r_ux, r_uy;
    logic [COORD_W-1:0] r_k, r_t, r_n, r_span;
    logic               r_x_left;
    logic [SUM_W-1:0]   r_sq_sum;
    logic [LIM_W-1:0]   r_lim;

    logic [COORD_W-1:0] adx, ady, dmin, dmax;
    logic               x_neg, y_neg;
    logic [ADDR_W-1:0]  cur_addr, waddr;
    logic               cur_in_grid;
    logic [CELL_W-1:0]  rd_data;
    logic               we;

    // Absolute differences and directions between start and end.
    assign x_neg = r_end_x < r_pos_x;
    assign y_neg = r_end_y < r_pos_y;
    assign adx   = x_neg ? (r_pos_x - r_end_x) : (r_end_x - r_pos_x);
    assign ady   = y_neg ? (r_pos_y - r_end_y) : (r_end_y - r_pos_y);
    assign dmin  = (adx < ady) ? adx : ady;
    assign dmax  = (adx < ady) ? ady : adx;

    assign cur_in_grid = (int'(r_cur_x) < GRID_SIDE) && (int'(r_cur_y) < GRID_SIDE);
    assign cur_addr    = ADDR_W'(r_cur_y) * ADDR_W'(GRID_SIDE) + ADDR_W'(r_cur_x);
    assign waddr       = i_cmd.clear_step ? r_clr_addr : cur_addr;
    assign we          = i_cmd.clear_step || i_cmd.cell_write;

    gvc_ram #(
        .WIDTH (CELL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (i_cmd.clear_step ? CELL_EMPTY : r_cell_type),
        .i_raddr (cur_addr),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_step <= STEP_RESET;
            r_clr_addr <= '0;
            r_chk_vld  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_max_step <= i_cfg_data;
            end
            if (i_cmd.clear_step) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
            r_chk_vld <= i_cmd.scan_step && cur_in_grid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pos_x     <= i_in_word.pos_x;
            r_pos_y     <= i_in_word.pos_y;
            r_end_x     <= i_in_word.end_x;
            r_end_y     <= i_in_word.end_y;
            r_cell_type <= i_in_word.cell_type;
            r_cur_x     <= i_in_word.pos_x;
            r_cur_y     <= i_in_word.pos_y;
            r_base_x    <= i_in_word.pos_x;
            r_base_y    <= i_in_word.pos_y;
        end
        if (i_cmd.setup) begin
            r_sq_sum <= SUM_W'(SQ_W'(adx) * SQ_W'(adx)) + SUM_W'(SQ_W'(ady) * SQ_W'(ady));
            r_lim    <= LIM_W'(r_max_step) * LIM_W'(r_max_step);
            r_ux     <= (adx == '0) ? '0 : (x_neg ? '1 : COORD_W'(1));
            r_uy     <= (ady == '0) ? '0 : (y_neg ? '1 : COORD_W'(1));
            r_x_left <= adx > ady;
            r_n      <= dmin;
            r_span   <= dmax - dmin;
            r_k      <= '0;
            r_t      <= '0;
        end
        if (i_cmd.scan_step) begin
            if (r_t == r_span) begin
                // Row done: move one diagonal step and restart the span.
                r_t      <= '0;
                r_k      <= r_k + COORD_W'(1);
                r_base_x <= r_base_x + r_ux;
                r_base_y <= r_base_y + r_uy;
                r_cur_x  <= r_base_x + r_ux;
                r_cur_y  <= r_base_y + r_uy;
            end else begin
                r_t <= r_t + COORD_W'(1);
                if (r_x_left) begin
                    r_cur_x <= r_cur_x + r_ux;
                end else begin
                    r_cur_y <= r_cur_y + r_uy;
                end
            end
        end
    end

    always_comb begin
        o_status.clear_last  = r_clr_addr == ADDR_W'(DEPTH - 1);
        o_status.too_far     = LIM_W'(r_sq_sum) > r_lim;
        o_status.same_point  = (r_pos_x == r_end_x) && (r_pos_y == r_end_y);
        o_status.scan_last   = (r_t == r_span) && (r_k == r_n);
        o_status.hit         = r_chk_vld && (rd_data == CELL_OBSTACLE);
        o_status.cell_empty  = rd_data == CELL_EMPTY;
        o_status.pos_in_grid = cur_in_grid;
    end

endmodule

// ===== hw/rtl/gvc_ctrl.sv =====
// ----------------------------------------------------------------------------
// gvc_ctrl
// Controller: sequences the clearing pass, cell writes and visibility
// queries, and holds the result word register of the output channel.
// ----------------------------------------------------------------------------
module gvc_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_op,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output gvc_pkg::t_out_word   o_out_word,
    input  gvc_pkg::t_dp_status  i_status,
    output gvc_pkg::t_ctrl_cmd   o_cmd
);
    import gvc_pkg::*;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WR_RD,
        ST_WR_CHK,
        ST_Q_SETUP,
        ST_Q_CHECK,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } t_state;

    t_state    r_state, n_state;
    t_out_word r_res, n_res;
    logic      r_out_vld, n_out_vld;
    t_out_word r_out_word, n_out_word;

    always_comb begin
        n_state    = r_state;
        n_res      = r_res;
        n_out_vld  = r_out_vld && i_out_stall;
        n_out_word = r_out_word;
        o_cmd      = '0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_status.clear_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_res      = '0;
                    n_state    = (i_in_op == OP_WRITE) ? ST_WR_RD : ST_Q_SETUP;
                end
            end
            ST_WR_RD: begin
                n_state = ST_WR_CHK;
            end
            ST_WR_CHK: begin
                if (i_status.pos_in_grid && !i_status.cell_empty) begin
                    n_res.write_ignored = 1'b1;
                end else if (i_status.pos_in_grid) begin
                    o_cmd.cell_write = 1'b1;
                end
                n_state = ST_DONE;
            end
            ST_Q_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state     = ST_Q_CHECK;
            end
            ST_Q_CHECK: begin
                if (i_status.too_far) begin
                    n_state = ST_DONE;
                end else if (i_status.same_point) begin
                    n_res.same_point_error = 1'b1;
                    n_state                = ST_DONE;
                end else begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_status.hit) begin
                    n_state = ST_DONE;
                end else begin
                    o_cmd.scan_step = 1'b1;
                    if (i_status.scan_last) begin
                        n_state = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                n_res.visible = !i_status.hit;
                n_state       = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_vld || !i_out_stall) begin
                    n_out_vld  = 1'b1;
                    n_out_word = r_res;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
        r_res      <= n_res;
        r_out_word <= n_out_word;
    end

    assign o_in_stall  = r_state != ST_IDLE;
    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out_word;

endmodule

// ===== hw/rtl/gvc_checker.sv =====
// ----------------------------------------------------------------------------
// gvc_checker
// Port level checks of the grid visibility checker, bound to its top level.
// ----------------------------------------------------------------------------
module gvc_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               o_in_stall,
    input  logic               o_out_valid,
    input  logic               i_out_stall,
    input  gvc_pkg::t_out_word o_out_word
);
    import gvc_pkg::*;

    // A stalled result word stays valid and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("result word changed while stalled");

    // The memory clearing pass keeps the input stalled right after reset.
    a_reset_stall: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("input not stalled after reset");

    // One item at a time: an accepted word makes the block busy.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input accepted back to back");

    // A result reports at most one of its three outcomes.
    a_one_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $onehot0({o_out_word.visible, o_out_word.same_point_error,
                                  o_out_word.write_ignored}))
        else $error("conflicting result flags");

endmodule

bind grid_visibility_checker gvc_checker u_gvc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);

// ===== dv/tb_grid_visibility_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_grid_visibility_checker
// Self-checking bench for the grid visibility checker. A queue-fed driver
// pushes cell writes and line of sight queries through the stall handshake.
// A monitor predicts each answer from a private copy of the cell grid and the
// step limit, then compares every result word field by field. The step limit
// is changed between phases while the block is drained, and both channels
// idle at random.
// ----------------------------------------------------------------------------
module tb_grid_visibility_checker;

    import gvc_pkg::*;

    // Cell kinds that the package does not name.
    localparam logic [CELL_W-1:0] CELL_POI = 2'd1;
    localparam logic [CELL_W-1:0] CELL_REF = 2'd2;

    localparam int GRID_LAST  = GRID_SIDE_DEF - 1;
    localparam int GRID_CELLS = GRID_SIDE_DEF * GRID_SIDE_DEF;

    // Timeout budget. It assumes every item scans the largest possible region
    // (about 1056 cells), waits out the longest sender gap and the longest
    // receiver stall, then takes the whole thing three times over. The reset
    // sweep of the cell memory is added on top.
    localparam int ITEM_BUDGET    = 2000;
    localparam int ITEM_CYCLES    = 1100;
    localparam int GAP_MAX        = 40;
    localparam int STALL_MAX      = 40;
    localparam int CYCLE_LIMIT    = 2 * GRID_CELLS
                                  + ITEM_BUDGET * (ITEM_CYCLES + GAP_MAX + STALL_MAX) * 3;
    localparam int DRAIN_CYCLES   = 64;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ITEMS    = 215;

    // Receiver behavior in a segment: no stalls, short scattered stalls, or
    // long alternating runs of stall and flow.
    typedef enum int {
        FLOW_FREE,
        FLOW_CHOPPY,
        FLOW_BLOCKY
    } t_flow_mode;

    // ------------------------------------------------------------------------
    // Clock, reset and the block's inputs, all known from time zero.
    // ------------------------------------------------------------------------
    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    t_in_word           i_in_word   = '0;
    logic               i_out_stall = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic [STEP_W-1:0]  i_cfg_data  = '0;
    logic               o_in_stall;
    logic               o_out_valid;
    t_out_word          o_out_word;
    logic               o_cfg_ready;

    always #5 i_clk = ~i_clk;

    grid_visibility_checker dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // ------------------------------------------------------------------------
    // Shadow state of the block and the bench bookkeeping.
    // ------------------------------------------------------------------------
    logic [CELL_W-1:0]  grid_model [0:GRID_CELLS-1];
    logic [STEP_W-1:0]  model_step_limit;

    t_in_word           item_queue[$];        // words waiting for the driver
    t_out_word          expected_answers[$];  // predicted result words, oldest first
    int                 written_spots[$];     // cells written so far, for rewrites

    logic               in_taken = 1'b0;      // input word accepted at the last edge
    int                 gap_left = 0;
    int                 burst_left = 0;
    t_flow_mode         flow_mode = FLOW_FREE;
    int                 flow_seg_left = 0;
    int                 flow_run_left = 0;
    logic               flow_run_stall = 1'b0;
    int                 mismatch_count = 0;
    int                 answer_count = 0;
    int                 cycle_count = 0;

    // ------------------------------------------------------------------------
    // Predictor helpers.
    // ------------------------------------------------------------------------
    function automatic int step_dir(int v);
        return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
    endfunction

    function automatic int magnitude(int v);
        return (v < 0) ? -v : v;
    endfunction

    // Works out the result word for one accepted input word and applies the
    // write, if any, to the shadow grid. Queries first compare squared lengths
    // in exact integers. A query in range walks the diagonal until one
    // coordinate lines up with the end, then from every diagonal point (the
    // start and the corner included) sweeps the leftover axis up to and
    // including the end's row or column. A pure diagonal or a pure axis line
    // falls out of the same double loop with one of the two spans at zero.
    function automatic t_out_word visibility_answer(t_in_word w);
        t_out_word   ans;
        int          sx, sy, ex, ey, dx, dy;
        int          ux, uy, x, y, n, vx, vy, span, cx, cy;
        int unsigned d2, lim2;
        logic        blocked;
        ans = '0;
        if (w.op == OP_WRITE) begin
            // Occupied cells keep their type; type zero into an empty cell is
            // a silent no-op that still reports success.
            if (grid_model[int'(w.pos_y) * GRID_SIDE_DEF + int'(w.pos_x)] != CELL_EMPTY) begin
                ans.write_ignored = 1'b1;
            end else begin
                grid_model[int'(w.pos_y) * GRID_SIDE_DEF + int'(w.pos_x)] = w.cell_type;
            end
            return ans;
        end
        sx = int'(w.pos_x);
        sy = int'(w.pos_y);
        ex = int'(w.end_x);
        ey = int'(w.end_y);
        dx = ex - sx;
        dy = ey - sy;
        d2 = dx * dx + dy * dy;
        lim2 = int'(model_step_limit) * int'(model_step_limit);
        if (d2 > lim2) begin
            return ans;
        end
        // The range check comes first, so a limit of zero still lets the
        // identical point error through.
        if (dx == 0 && dy == 0) begin
            ans.same_point_error = 1'b1;
            return ans;
        end
        ux = step_dir(dx);
        uy = step_dir(dy);
        x = sx;
        y = sy;
        n = 0;
        while (x != ex && y != ey) begin
            x += ux;
            y += uy;
            n++;
        end
        vx = step_dir(ex - x);
        vy = step_dir(ey - y);
        span = magnitude(ex - x) + magnitude(ey - y);
        blocked = 1'b0;
        for (int k = 0; k <= n; k++) begin
            for (int t = 0; t <= span; t++) begin
                cx = sx + k * ux + t * vx;
                cy = sy + k * uy + t * vy;
                if (grid_model[cy * GRID_SIDE_DEF + cx] == CELL_OBSTACLE) begin
                    blocked = 1'b1;
                end
            end
        end
        ans.visible = !blocked;
        return ans;
    endfunction

    // ------------------------------------------------------------------------
    // Reporting.
    // ------------------------------------------------------------------------
    task automatic report_mismatch(string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------------
    // Stimulus building.
    // ------------------------------------------------------------------------
    function automatic logic [COORD_W-1:0] clamp_coord(int v);
        if (v < 0) begin
            return '0;
        end else if (v > GRID_LAST) begin
            return COORD_W'(GRID_LAST);
        end
        return v[COORD_W-1:0];
    endfunction

    // End fields of a write carry random content; the block must ignore them.
    task automatic push_write(int x, int y, logic [CELL_W-1:0] kind);
        t_in_word w;
        w.op        = OP_WRITE;
        w.pos_x     = clamp_coord(x);
        w.pos_y     = clamp_coord(y);
        w.end_x     = COORD_W'($urandom_range(0, GRID_LAST));
        w.end_y     = COORD_W'($urandom_range(0, GRID_LAST));
        w.cell_type = kind;
        written_spots = {written_spots, int'(w.pos_y) * GRID_SIDE_DEF + int'(w.pos_x)};
        item_queue = {item_queue, w};
    endtask

    // The cell type of a query carries random content as well.
    task automatic push_query(int sx, int sy, int ex, int ey);
        t_in_word w;
        w.op        = OP_QUERY;
        w.pos_x     = clamp_coord(sx);
        w.pos_y     = clamp_coord(sy);
        w.end_x     = clamp_coord(ex);
        w.end_y     = clamp_coord(ey);
        w.cell_type = CELL_W'($urandom_range(0, 3));
        item_queue = {item_queue, w};
    endtask

    // Random traffic. Activity is concentrated in a 16 x 16 window that moves
    // now and then, so that written obstacles actually land on the lines that
    // later queries scan. Most queries stay within reach of the current step
    // limit (plus one, to straddle the range edge); the rest are identical
    // points, straight or diagonal lines, and far endpoints anywhere.
    task automatic queue_random_items(int count);
        int wx, wy, reach, roll, sub, sx, sy, ex, ey, len, ux, uy, spot, kind_roll;
        logic [CELL_W-1:0] kind;
        reach = (model_step_limit > 12) ? 12 : int'(model_step_limit) + 1;
        wx = 0;
        wy = 0;
        for (int i = 0; i < count; i++) begin
            if (i % 40 == 0) begin
                wx = $urandom_range(0, GRID_SIDE_DEF - 16);
                wy = $urandom_range(0, GRID_SIDE_DEF - 16);
            end
            roll = $urandom_range(0, 99);
            if (roll < 5) begin
                sx = $urandom_range(0, GRID_LAST);
                sy = $urandom_range(0, GRID_LAST);
            end else begin
                sx = wx + int'($urandom_range(0, 15));
                sy = wy + int'($urandom_range(0, 15));
            end
            if (roll < 40) begin
                // A share of the writes go back to cells already written.
                if (roll >= 28 && written_spots.size() > 0) begin
                    spot = written_spots[$urandom_range(0, written_spots.size() - 1)];
                    sx = spot % GRID_SIDE_DEF;
                    sy = spot / GRID_SIDE_DEF;
                end
                kind_roll = $urandom_range(0, 9);
                if (kind_roll == 0) begin
                    kind = CELL_EMPTY;
                end else if (kind_roll < 4) begin
                    kind = CELL_OBSTACLE;
                end else if (kind_roll < 7) begin
                    kind = CELL_POI;
                end else begin
                    kind = CELL_REF;
                end
                push_write(sx, sy, kind);
            end else begin
                sub = $urandom_range(0, 99);
                if (sub < 10) begin
                    ex = sx;
                    ey = sy;
                end else if (sub < 25) begin
                    len = $urandom_range(1, reach);
                    ux = int'($urandom_range(0, 2)) - 1;
                    uy = int'($urandom_range(0, 2)) - 1;
                    if (ux == 0 && uy == 0) begin
                        ux = 1;
                    end
                    ex = sx + len * ux;
                    ey = sy + len * uy;
                end else if (sub < 90) begin
                    ex = sx + int'($urandom_range(0, 2 * reach)) - reach;
                    ey = sy + int'($urandom_range(0, 2 * reach)) - reach;
                end else begin
                    ex = $urandom_range(0, GRID_LAST);
                    ey = $urandom_range(0, GRID_LAST);
                end
                push_query(sx, sy, ex, ey);
            end
        end
    endtask

    // Blocks until the driver has nothing left and every predicted word has
    // come back. Sampled at the rising edge, where a word still on the input
    // shows up as a high valid.
    task automatic wait_drained();
        do @(posedge i_clk);
        while (item_queue.size() != 0 || i_in_valid || expected_answers.size() != 0);
    endtask

    // Writes the step limit and mirrors it in the shadow copy once the
    // handshake completes.
    task automatic write_step_limit(logic [STEP_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        model_step_limit = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Input driver. Words leave the queue in bursts of random length with
    // random gaps in between; a gap of zero gives back-to-back traffic. A word
    // that was not taken at the last edge stays on the bus untouched, and
    // valid is never lowered and raised again within one step.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !in_taken) begin
            // Stalled: hold the word.
        end else if (gap_left > 0) begin
            i_in_valid <= 1'b0;
            gap_left--;
        end else if (item_queue.size() > 0) begin
            i_in_valid <= 1'b1;
            i_in_word  <= item_queue.pop_front();
            if (burst_left <= 1) begin
                burst_left = $urandom_range(1, 30);
                gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(0, GAP_MAX)
                                                       : $urandom_range(0, 4);
            end else begin
                burst_left--;
            end
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Result receiver stall pattern. Segments of random length each
    // pick a mode: free flow, short scattered stalls, or long runs.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (flow_seg_left == 0) begin
            flow_mode = t_flow_mode'($urandom_range(0, 2));
            flow_seg_left = $urandom_range(50, 400);
        end
        flow_seg_left--;
        case (flow_mode)
            FLOW_FREE: begin
                i_out_stall <= 1'b0;
            end
            FLOW_CHOPPY: begin
                i_out_stall <= ($urandom_range(0, 3) == 0);
            end
            default: begin
                if (flow_run_left == 0) begin
                    flow_run_stall = !flow_run_stall;
                    flow_run_left = $urandom_range(1, 30);
                end
                flow_run_left--;
                i_out_stall <= flow_run_stall;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Monitor. Everything is sampled at the rising edge, where the block's
    // outputs still hold their pre-edge values. The result side is handled
    // before the input side, so a word accepted at this edge never pairs with
    // a result leaving at the same edge.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_out_word want;
        if (!i_rst_n) begin
            in_taken = 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_answers.size() == 0) begin
                    report_mismatch($sformatf("result word %b with no item pending",
                                              o_out_word));
                end else begin
                    want = expected_answers.pop_front();
                    if (o_out_word.visible !== want.visible) begin
                        report_mismatch($sformatf("result %0d visible got %b want %b",
                                                  answer_count, o_out_word.visible,
                                                  want.visible));
                    end
                    if (o_out_word.same_point_error !== want.same_point_error) begin
                        report_mismatch($sformatf("result %0d same_point_error got %b want %b",
                                                  answer_count, o_out_word.same_point_error,
                                                  want.same_point_error));
                    end
                    if (o_out_word.write_ignored !== want.write_ignored) begin
                        report_mismatch($sformatf("result %0d write_ignored got %b want %b",
                                                  answer_count, o_out_word.write_ignored,
                                                  want.write_ignored));
                    end
                end
                answer_count++;
            end
            in_taken = i_in_valid && !o_in_stall;
            if (in_taken) begin
                expected_answers = {expected_answers, visibility_answer(i_in_word)};
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TIMEOUT after %0d cycles, %0d results outstanding",
                     cycle_count, expected_answers.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial begin : sequence_main
        logic [STEP_W-1:0] phase_limits [RANDOM_PHASES];
        phase_limits = '{7'd8, 7'd127, 7'd3, 7'd0, 7'd20, 7'd11, 7'd63, 7'd1};
        phase_limits[RANDOM_PHASES-1] = STEP_W'($urandom_range(1, 126));

        for (int i = 0; i < GRID_CELLS; i++) begin
            grid_model[i] = CELL_EMPTY;
        end
        model_step_limit = STEP_RESET;

        // Synchronous reset held low at the start. The block then clears
        // its memory with the input stalled; the driver simply waits.
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed items at the reset step limit of 8. Corner writes, a type
        // zero write that leaves the cell empty, and a rewrite of an occupied
        // cell come first.
        push_write(0, 0, CELL_POI);
        push_write(GRID_LAST, GRID_LAST, CELL_REF);
        push_write(GRID_LAST, 0, CELL_OBSTACLE);
        push_write(0, GRID_LAST, CELL_EMPTY);
        push_write(0, GRID_LAST, CELL_POI);
        push_write(0, 0, CELL_OBSTACLE);
        // Identical points, far out of range, exactly at the limit and just
        // past it.
        push_query(5, 5, 5, 5);
        push_query(0, 0, 40, 40);
        push_query(10, 10, 18, 10);
        push_query(10, 10, 18, 11);
        // An obstacle on a straight line, then on the sweep after a diagonal
        // leg; a clear vertical sweep and a clear diagonal.
        push_write(14, 10, CELL_OBSTACLE);
        push_query(10, 10, 18, 10);
        push_query(10, 10, 17, 12);
        push_query(20, 20, 23, 26);
        push_query(20, 20, 24, 24);
        // Obstacle on the diagonal seen from both directions, an obstacle on
        // the end cell, a clear run along the grid edge, and one on the start.
        push_write(22, 22, CELL_OBSTACLE);
        push_query(20, 20, 24, 24);
        push_query(24, 24, 20, 20);
        push_query(GRID_LAST, 5, GRID_LAST, 0);
        push_query(GRID_LAST, GRID_LAST, GRID_LAST - 6, GRID_LAST);
        push_query(14, 10, 16, 10);
        wait_drained();

        // Step limit zero: every distinct pair is out of range, while the
        // identical point error still comes through.
        write_step_limit('0);
        push_query(1, 1, 1, 2);
        push_query(1, 1, 1, 1);
        wait_drained();

        // Largest step limit: full grid diagonals and a long clear sweep.
        write_step_limit(7'd127);
        push_query(0, 0, GRID_LAST, GRID_LAST);
        push_query(GRID_LAST, 0, 0, GRID_LAST);
        push_query(40, 40, GRID_LAST, 50);
        wait_drained();

        // Random phases, each under its own step limit. Every phase drains
        // completely before the limit changes, so the sender also pauses
        // until all results are in.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            write_step_limit(phase_limits[p]);
            queue_random_items(PHASE_ITEMS);
            wait_drained();
        end

        // Give a stray extra result time to show up.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_answers.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", expected_answers.size()));
        end

        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
